// File: design/aesctr_pkg.sv
`default_nettype none
package aesctr_pkg;

    localparam int NR = 14;

    localparam logic [2:0] CFG_KEY0    = 3'd0;
    localparam logic [2:0] CFG_KEY1    = 3'd1;
    localparam logic [2:0] CFG_KEY2    = 3'd2;
    localparam logic [2:0] CFG_KEY3    = 3'd3;
    localparam logic [2:0] CFG_NONCE_H = 3'd4;
    localparam logic [2:0] CFG_NONCE_L = 3'd5;

    // payload that travels down the round pipeline
    typedef struct packed {
        logic [127:0] state;
        logic [255:0] key;   // eight schedule words, oldest in the top bits
        logic [127:0] data;
        logic [15:0]  mask;  // bit i selects byte i
    } t_stage;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] col);
        logic [7:0] a, b, d, e;
        a = col[31:24];
        b = col[23:16];
        d = col[15:8];
        e = col[7:0];
        return {xt(a) ^ xt(b) ^ b ^ d ^ e,
                a ^ xt(b) ^ xt(d) ^ d ^ e,
                a ^ b ^ xt(d) ^ xt(e) ^ e,
                xt(a) ^ a ^ b ^ d ^ xt(e)};
    endfunction

endpackage
`default_nettype wire

// File: design/aesctr_in_if.sv
`default_nettype none
interface aesctr_in_if;
    logic        valid;
    logic        ready;
    logic [59:0] block_index;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [3:0]  first_byte;
    logic [4:0]  byte_count;

    modport source (output valid, block_index, data_high, data_low, first_byte, byte_count,
                    input ready);
    modport sink (input valid, block_index, data_high, data_low, first_byte, byte_count,
                  output ready);
endinterface
`default_nettype wire

// File: design/aesctr_out_if.sv
`default_nettype none
interface aesctr_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_high;
    logic [63:0] out_low;

    modport source (output valid, out_high, out_low, input ready);
    modport sink (input valid, out_high, out_low, output ready);
endinterface
`default_nettype wire

// File: design/aesctr_round.sv
`default_nettype none
module aesctr_round
    import aesctr_pkg::*;
#(
    parameter int ROUND = 1
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_adv,
    input  wire logic   i_valid,
    input  wire t_stage i_stage,
    output logic        o_valid,
    output t_stage      o_stage
);

    localparam logic [7:0] RCON = 8'(1 << ((ROUND + 1) / 2 - 1));

    logic [127:0] sb;
    logic [127:0] sr;
    logic [127:0] mc;
    logic [127:0] ks;
    logic [127:0] bmask;
    logic [31:0]  t;
    logic [31:0]  nw0, nw1, nw2, nw3;
    t_stage       n_stage;
    logic         r_valid;
    t_stage       r_stage;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sb[127 - 8*i -: 8] = SBOX[i_stage.state[127 - 8*i -: 8]];
        end
        // byte r of column c comes from column c + r
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sr[127 - 8*(r + 4*c) -: 8] = sb[127 - 8*(r + 4*((c + r) % 4)) -: 8];
            end
        end
        for (int c = 0; c < 4; c++) begin
            mc[127 - 32*c -: 32] = mix_col(sr[127 - 32*c -: 32]);
        end
        if (ROUND < NR) begin
            ks = mc ^ i_stage.key[127:0];
        end else begin
            ks = sr ^ i_stage.key[127:0];
        end

        // advance the key schedule by four words
        if (ROUND % 2 == 1) begin
            t = sub_word({i_stage.key[23:0], i_stage.key[31:24]}) ^ {RCON, 24'h0};
        end else begin
            t = sub_word(i_stage.key[31:0]);
        end
        nw0 = i_stage.key[255:224] ^ t;
        nw1 = i_stage.key[223:192] ^ nw0;
        nw2 = i_stage.key[191:160] ^ nw1;
        nw3 = i_stage.key[159:128] ^ nw2;

        for (int i = 0; i < 16; i++) begin
            bmask[127 - 8*i -: 8] = {8{i_stage.mask[i]}};
        end

        n_stage      = i_stage;
        n_stage.key  = {i_stage.key[127:0], nw0, nw1, nw2, nw3};
        if (ROUND < NR) begin
            n_stage.state = ks;
        end else begin
            n_stage.state = i_stage.data ^ (ks & bmask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
`default_nettype wire

// File: design/aes256_ctr_keystream_xor.sv
`default_nettype none
// Pipeline: one counter stage, then one register stage per AES round (14 rounds
// unrolled), between an accepted item and its valid result.
// Throughput: one item per cycle; the whole pipeline holds while the result stalls.
// Reset clears all stage valid bits and sets key and nonce registers to zero.
module aes256_ctr_keystream_xor
    import aesctr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    aesctr_in_if.sink   i_in,
    aesctr_out_if.source o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);

    logic [63:0]  r_key0, r_key1, r_key2, r_key3;
    logic [63:0]  r_nonce_h, r_nonce_l;
    logic         adv;
    logic [127:0] ctr;
    logic [5:0]   win_end;
    t_stage       n_stage0;
    t_stage       r_stage0;
    logic         r_valid0;
    logic         vld [NR + 1];
    t_stage       stg [NR + 1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0    <= '0;
            r_key1    <= '0;
            r_key2    <= '0;
            r_key3    <= '0;
            r_nonce_h <= '0;
            r_nonce_l <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY0:    r_key0    <= i_cfg_data;
                CFG_KEY1:    r_key1    <= i_cfg_data;
                CFG_KEY2:    r_key2    <= i_cfg_data;
                CFG_KEY3:    r_key3    <= i_cfg_data;
                CFG_NONCE_H: r_nonce_h <= i_cfg_data;
                CFG_NONCE_L: r_nonce_l <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hold the whole pipeline while the output item waits
    assign adv        = !vld[NR] || o_out.ready;
    assign i_in.ready = adv;

    always_comb begin
        ctr     = {r_nonce_h, r_nonce_l} + {68'h0, i_in.block_index};
        win_end = {2'b00, i_in.first_byte} + {1'b0, i_in.byte_count};
        n_stage0.key   = {r_key0, r_key1, r_key2, r_key3};
        n_stage0.state = ctr ^ {r_key0, r_key1};
        n_stage0.data  = {i_in.data_high, i_in.data_low};
        for (int i = 0; i < 16; i++) begin
            n_stage0.mask[i] = (6'(i) >= {2'b00, i_in.first_byte}) && (6'(i) < win_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (adv) begin
            r_valid0 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_stage0 <= n_stage0;
        end
    end

    assign vld[0] = r_valid0;
    assign stg[0] = r_stage0;

    for (genvar g = 1; g <= NR; g++) begin : g_round
        aesctr_round #(.ROUND(g)) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (vld[g - 1]),
            .i_stage (stg[g - 1]),
            .o_valid (vld[g]),
            .o_stage (stg[g])
        );
    end

    assign o_out.valid    = vld[NR];
    assign o_out.out_high = stg[NR].state[127:64];
    assign o_out.out_low  = stg[NR].state[63:0];

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top
    import aesctr_pkg::*;
;

    localparam int LATENCY   = 15;
    localparam int CYCLE_CAP = 1500000;

    typedef struct packed {
        logic [59:0] block_index;
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [3:0]  first_byte;
        logic [4:0]  byte_count;
    } t_block;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } t_cipher;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    aesctr_in_if  in_ch();
    aesctr_out_if out_ch();

    aes256_ctr_keystream_xor u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    logic [63:0] key_regs [4];
    logic [63:0] nonce_hi, nonce_lo;

    t_block  block_q [$];
    t_cipher cipher_q [$];
    int      send_idle_pct, recv_stall_pct;
    int      errors;
    int      cycles;
    bit      feeding_done;

    localparam logic [7:0] RCON [8] = '{8'h00, 8'h01, 8'h02, 8'h04,
                                        8'h08, 8'h10, 8'h20, 8'h40};

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Encrypt one counter block under the current key registers.
    function automatic logic [127:0] aes256_encrypt(input logic [127:0] ctr);
        logic [31:0]  w [60];
        logic [31:0]  t;
        logic [7:0]   s [16];
        logic [7:0]   u [16];
        logic [7:0]   a, b, d, e;
        logic [127:0] res;
        for (int i = 0; i < 4; i++) begin
            w[2*i]   = key_regs[i][63:32];
            w[2*i+1] = key_regs[i][31:0];
        end
        for (int i = 8; i < 60; i++) begin
            t = w[i-1];
            if (i % 8 == 0)
                t = sbox_word({t[23:0], t[31:24]}) ^ {RCON[(i/8) % 8], 24'h0};
            else if (i % 8 == 4)
                t = sbox_word(t);
            w[i] = w[i-8] ^ t;
        end
        for (int i = 0; i < 16; i++)
            s[i] = ctr[127-8*i -: 8] ^ w[i/4][31-8*(i%4) -: 8];
        for (int r = 1; r <= 14; r++) begin
            for (int c = 0; c < 4; c++)
                for (int k = 0; k < 4; k++)
                    u[k+4*c] = SBOX[s[k + 4*((c+k) % 4)]];
            for (int c = 0; c < 4; c++) begin
                a = u[4*c]; b = u[4*c+1]; d = u[4*c+2]; e = u[4*c+3];
                if (r < 14) begin
                    s[4*c]   = gf_double(a) ^ gf_double(b) ^ b ^ d ^ e;
                    s[4*c+1] = a ^ gf_double(b) ^ gf_double(d) ^ d ^ e;
                    s[4*c+2] = a ^ b ^ gf_double(d) ^ gf_double(e) ^ e;
                    s[4*c+3] = gf_double(a) ^ a ^ b ^ d ^ gf_double(e);
                end else begin
                    s[4*c] = a; s[4*c+1] = b; s[4*c+2] = d; s[4*c+3] = e;
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] ^= w[4*r + i/4][31-8*(i%4) -: 8];
        end
        for (int i = 0; i < 16; i++)
            res[127-8*i -: 8] = s[i];
        return res;
    endfunction

    function automatic t_cipher ctr_xor(input t_block blk);
        logic [127:0] ctr, ks, data, mask;
        t_cipher      res;
        ctr  = {nonce_hi, nonce_lo} + {68'h0, blk.block_index};
        ks   = aes256_encrypt(ctr);
        data = {blk.data_high, blk.data_low};
        mask = '0;
        for (int i = 0; i < 16; i++)
            if (i >= blk.first_byte && i < int'(blk.first_byte) + int'(blk.byte_count))
                mask[127-8*i -: 8] = 8'hff;
        {res.out_high, res.out_low} = data ^ (ks & mask);
        return res;
    endfunction

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (block_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_block blk;
                blk = block_q.pop_front();
                cipher_q.push_back(ctr_xor(blk));
                in_ch.valid       <= 1'b1;
                in_ch.block_index <= blk.block_index;
                in_ch.data_high   <= blk.data_high;
                in_ch.data_low    <= blk.data_low;
                in_ch.first_byte  <= blk.first_byte;
                in_ch.byte_count  <= blk.byte_count;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (cipher_q.size() == 0) begin
                    $display("%0t: unexpected item %h %h", $time,
                             out_ch.out_high, out_ch.out_low);
                    errors++;
                end else begin
                    t_cipher exp_c;
                    exp_c = cipher_q.pop_front();
                    if (out_ch.out_high !== exp_c.out_high) begin
                        $display("%0t: out_high expected %h actual %h", $time,
                                 exp_c.out_high, out_ch.out_high);
                        errors++;
                    end
                    if (out_ch.out_low !== exp_c.out_low) begin
                        $display("%0t: out_low expected %h actual %h", $time,
                                 exp_c.out_low, out_ch.out_low);
                        errors++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_block rand_block();
        t_block blk;
        blk.block_index = 60'({$urandom(), $urandom()});
        if ($urandom_range(3) == 0)
            blk.block_index = $urandom_range(1) ? '1 : 60'($urandom_range(7));
        blk.data_high  = rand64();
        blk.data_low   = rand64();
        blk.first_byte = 4'($urandom_range(15));
        blk.byte_count = 5'($urandom_range(31));
        return blk;
    endfunction

    task automatic drain();
        while (block_q.size() > 0 || cipher_q.size() > 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_KEY0:    key_regs[0] = val;
            CFG_KEY1:    key_regs[1] = val;
            CFG_KEY2:    key_regs[2] = val;
            CFG_KEY3:    key_regs[3] = val;
            CFG_NONCE_H: nonce_hi = val;
            CFG_NONCE_L: nonce_lo = val;
            default: ;
        endcase
    endtask

    task automatic load_setting(input logic [63:0] k0, k1, k2, k3, nh, nl);
        write_reg(CFG_KEY0, k0);
        write_reg(CFG_KEY1, k1);
        write_reg(CFG_KEY2, k2);
        write_reg(CFG_KEY3, k3);
        write_reg(CFG_NONCE_H, nh);
        write_reg(CFG_NONCE_L, nl);
    endtask

    initial begin
        t_block blk;
        errors = 0;
        cycles = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 4; i++) key_regs[i] = '0;
        nonce_hi = '0;
        nonce_lo = '0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_KEY0;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.block_index = '0;
        in_ch.data_high   = '0;
        in_ch.data_low    = '0;
        in_ch.first_byte  = '0;
        in_ch.byte_count  = '0;
        out_ch.ready = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: all-zero key, then windows, empty window, clipping, wrap
        for (int i = 0; i < 18; i++) begin
            blk.block_index = (i < 9) ? 60'(i) : '1;
            blk.data_high   = (i % 2) ? '1 : '0;
            blk.data_low    = (i % 3) ? 64'h0123456789abcdef : '1;
            blk.first_byte  = 4'(i * 5);
            blk.byte_count  = (i == 0) ? 5'd16 : (i == 1) ? 5'd0 : (i == 2) ? 5'd31
                            : 5'($urandom_range(1, 16));
            if (i == 3) blk.first_byte = 4'd15;
            block_q.push_back(blk);
        end
        drain();

        // counter overflow across all 128 bits, also an ignored register index
        load_setting('1, '1, '1, '1, '1, 64'hffff_ffff_ffff_fff0);
        write_reg(3'd7, 64'h5555);
        for (int i = 0; i < 6; i++) begin
            blk = rand_block();
            blk.block_index = (i < 3) ? 60'(15 + i) : '1;
            blk.first_byte  = '0;
            blk.byte_count  = 5'd16;
            block_q.push_back(blk);
        end
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                3: begin send_idle_pct = 36; recv_stall_pct = 36; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            load_setting(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
            for (int i = 0; i < 210; i++) begin
                block_q.push_back(rand_block());
                // hold off until the pipeline is empty once per phase
                if (i == 100) begin
                    while (block_q.size() > 0 || cipher_q.size() > 0) @(posedge i_clk);
                end
            end
            drain();
        end

        load_setting('0, '0, '0, '0, '0, '0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        block_q.push_back(rand_block());
        drain();

        if (errors == 0 && cipher_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: aes256_ctr_keystream_xor.f
design/aesctr_pkg.sv
design/aesctr_in_if.sv
design/aesctr_out_if.sv
design/aesctr_round.sv
design/aes256_ctr_keystream_xor.sv
sim/tb_top.sv
